FILE: rtl/core/swmm_pkg.sv
// Shared types and constants for the sliding window min/max unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package swmm_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

    localparam logic signed [DATA_W-1:0] DATA_POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic                     vld;
        logic signed [DATA_W-1:0] min;
        logic signed [DATA_W-1:0] max;
    } t_token;

    typedef struct packed {
        logic shift;    // sample chain moves one place
        logic advance;  // token chain moves one place
    } t_ctrl;

endpackage
`default_nettype wire

FILE: rtl/core/swmm_cell.sv
// One chain cell: holds one window sample and folds it into the passing token.
// Depends on swmm_pkg.
`default_nettype none
module swmm_cell
    import swmm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_ctrl                    i_ctl,
    input  wire logic                     i_en,
    input  wire logic signed [DATA_W-1:0] i_sample,
    output logic signed [DATA_W-1:0]      o_sample,
    input  wire t_token                   i_tok,
    output t_token                        o_tok
);

    logic signed [DATA_W-1:0] r_sample;
    t_token                   r_tok;
    t_token                   n_tok;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_sample <= i_sample;
        end
    end

    always_comb begin
        n_tok = i_tok;
        if (i_en && (r_sample < i_tok.min)) begin
            n_tok.min = r_sample;
        end
        if (i_en && (r_sample > i_tok.max)) begin
            n_tok.max = r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (i_ctl.advance) begin
            r_tok.vld <= n_tok.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_tok.min <= n_tok.min;
            r_tok.max <= n_tok.max;
        end
    end

    assign o_sample = r_sample;
    assign o_tok    = r_tok;

endmodule
`default_nettype wire

FILE: rtl/core/sliding_window_min_max_unit.sv
// Sliding window min/max over a chain of WINDOW_MAX cells; uses swmm_pkg and swmm_cell.
// o_out_valid rises once the sweep token has passed r_inject, each cell in turn and the
// output register; the token waits at the chain end while a previous result is held by
// output stall. Input stalls during the sweep, so no new sample is taken until the result
// is loaded; a sample that produces no result does not stall input.
// Reset (synchronous, active low): fill count zero, window size 1, no result held.
`default_nettype none
module sliding_window_min_max_unit
    import swmm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CNT_W-1:0]         i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic signed [DATA_W-1:0] i_sample,
    input  wire logic                     i_start_req,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [DATA_W-1:0]      o_window_min,
    output logic signed [DATA_W-1:0]      o_window_max
);

    logic [CNT_W-1:0]         r_win_cfg;
    logic [CNT_W-1:0]         r_win;
    logic [CNT_W-1:0]         r_fill;
    logic [CNT_W-1:0]         n_fill;
    logic [CNT_W-1:0]         eff_win;
    logic                     r_busy;
    logic                     r_inject;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_min;
    logic signed [DATA_W-1:0] r_max;
    logic                     in_xfer;
    logic                     produce;
    logic                     load_out;
    t_ctrl                    ctl;
    t_token                   tok_head;
    logic signed [DATA_W-1:0] smp [WINDOW_MAX+1];
    t_token                   tok [WINDOW_MAX+1];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_busy;
    assign in_xfer     = i_in_valid && !r_busy;

    always_comb begin
        eff_win = r_win_cfg;
        if (r_win_cfg == '0) begin
            eff_win = CNT_W'(1);
        end else if (r_win_cfg > CNT_W'(WINDOW_MAX)) begin
            eff_win = CNT_W'(WINDOW_MAX);
        end
    end

    always_comb begin
        if (i_start_req) begin
            n_fill = CNT_W'(1);
        end else if (r_fill < CNT_W'(WINDOW_MAX)) begin
            n_fill = r_fill + CNT_W'(1);
        end else begin
            n_fill = r_fill;
        end
    end

    assign produce  = n_fill >= eff_win;
    assign load_out = tok[WINDOW_MAX].vld && (!r_out_valid || !i_out_stall);

    assign ctl.shift   = in_xfer;
    assign ctl.advance = !tok[WINDOW_MAX].vld || load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_cfg   <= CNT_W'(1);
            r_fill      <= '0;
            r_busy      <= 1'b0;
            r_inject    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_win_cfg <= i_cfg_data;
            end
            if (in_xfer) begin
                r_fill <= n_fill;
            end
            r_inject <= in_xfer && produce;
            if (in_xfer && produce) begin
                r_busy <= 1'b1;
            end else if (load_out) begin
                r_busy <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_win <= eff_win;
        end
        if (load_out) begin
            r_min <= tok[WINDOW_MAX].min;
            r_max <= tok[WINDOW_MAX].max;
        end
    end

    assign tok_head.vld = r_inject;
    assign tok_head.min = DATA_POS_MAX;
    assign tok_head.max = DATA_NEG_MIN;
    assign smp[0]       = i_sample;
    assign tok[0]       = tok_head;

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        swmm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_en     (CNT_W'(g) < r_win),
            .i_sample (smp[g]),
            .o_sample (smp[g+1]),
            .i_tok    (tok[g]),
            .o_tok    (tok[g+1])
        );
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_min = r_min;
    assign o_window_max = r_max;

endmodule
`default_nettype wire

FILE: rtl/core/swmm_checker.sv
// Port-level checker for sliding_window_min_max_unit, bound to the top level.
// Depends on swmm_pkg.
`default_nettype none
module swmm_checker
    import swmm_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_in_valid,
    input wire logic                     o_in_stall,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_stall,
    input wire logic signed [DATA_W-1:0] o_window_min,
    input wire logic signed [DATA_W-1:0] o_window_max
);

    // after reset nothing is held and input is open
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("state not cleared by reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_window_min) && $stable(o_window_max))
        else $error("stalled result changed");

    // a new result only ends a sweep, during which input is stalled
    a_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a sweep");

    // no result the cycle right after an input transfer
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result too early");

endmodule

bind sliding_window_min_max_unit swmm_checker u_swmm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_window_min (o_window_min),
    .o_window_max (o_window_max)
);
`default_nettype wire
